/* hw/rtl/pdt_pkg.sv */
// shared constants, types and helpers for the priority donation table
`default_nettype none

package pdt_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int NUM_LEVELS = 4;

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CMD_W  = 3;
  localparam int SLOT_W = 6;
  localparam int TID_W  = 16;
  localparam int ID_W   = 15;
  localparam int LVL_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BOOST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PICK,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic pick;
    logic read;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_stat_t;

  function automatic logic [LVL_W-1:0] clamp_level(logic [LVL_W-1:0] v);
    if (32'(v) >= NUM_LEVELS) begin
      return LVL_W'(NUM_LEVELS - 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pdt_req_if.sv */
// request channel: command transaction into the table
`default_nettype none

interface pdt_req_if
  import pdt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [SLOT_W-1:0]       slot;
  logic signed [TID_W-1:0] task_id;
  logic [LVL_W-1:0]        level;

  modport source (output valid, command, slot, task_id, level, input ready);
  modport sink   (input valid, command, slot, task_id, level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pdt_rsp_if.sv */
// response channel: one result transaction per command
`default_nettype none

interface pdt_rsp_if
  import pdt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             found;
  logic             changed;
  logic [LVL_W-1:0] level_before;
  logic [LVL_W-1:0] level_after;
  logic             donation_active;

  modport source (output valid, found, changed, level_before, level_after,
                  donation_active, input ready);
  modport sink   (input valid, found, changed, level_before, level_after,
                  donation_active, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pdt_ctrl.sv */
// controller state machine sequencing compare, pick, read and write
`default_nettype none

module pdt_ctrl
  import pdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CMP;
      end
      ST_CMP:  state_next = ST_PICK;
      ST_PICK: state_next = ST_READ;
      ST_READ: state_next = ST_WRITE;
      ST_WRITE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_CMP:   cmd.compare = 1'b1;
      ST_PICK:  cmd.pick    = 1'b1;
      ST_READ:  cmd.read    = 1'b1;
      ST_WRITE: cmd.commit  = !stat.out_busy;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/pdt_dp.sv */
// datapath: id match row, slot picker, level memories and result register
`default_nettype none

module pdt_dp
  import pdt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ctrl_cmd_t cmd,
  output ctrl_stat_t     stat,
  pdt_req_if.sink        req,
  pdt_rsp_if.source      rsp
);

  // captured transaction
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TID_W-1:0]  tid_r;
  logic [LVL_W-1:0]  lvl_r;

  // per-slot flags and id row
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] sv;
  logic [ID_W-1:0]      id_row [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hit;

  // level memories
  logic [LVL_W-1:0] level_mem [NUM_SLOTS];
  logic [LVL_W-1:0] saved_mem [NUM_SLOTS];

  logic [IDX_W-1:0] idx_r;
  logic             any_r;
  logic [IDX_W-1:0] pick_idx;
  logic             pick_any;
  logic             slot_ok;

  logic [LVL_W-1:0] cur_rd;
  logic [LVL_W-1:0] sav_rd;
  logic             sv_rd;

  // commit decode
  logic             ok;
  logic [LVL_W-1:0] lvl_new;
  logic             sv_new;
  logic             wr_lvl;
  logic             wr_sav;
  logic             wr_id;
  logic             set_used;
  logic             clr_used;
  logic             res_found;
  logic             res_changed;
  logic [LVL_W-1:0] res_before;
  logic [LVL_W-1:0] res_after;
  logic             res_active;

  // result register
  logic             out_valid;
  logic             out_found;
  logic             out_changed;
  logic [LVL_W-1:0] out_before;
  logic [LVL_W-1:0] out_after;
  logic             out_active;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= req.command;
      slot_r <= req.slot;
      tid_r  <= req.task_id;
      lvl_r  <= clamp_level(req.level);
    end
  end

  assign slot_ok = (32'(slot_r) < NUM_SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        hit[i] <= used[i] && (id_row[i] == tid_r[ID_W-1:0]);
      end
    end
  end

  // lowest numbered matching slot wins
  always_comb begin
    pick_idx = '0;
    pick_any = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick_idx = IDX_W'(i);
        pick_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      if (cmd_r == CMD_ATTACH || cmd_r == CMD_FREE) begin
        idx_r <= IDX_W'(slot_r);
        any_r <= slot_ok;
      end else begin
        idx_r <= pick_idx;
        any_r <= pick_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      cur_rd <= level_mem[idx_r];
    end
    if (cmd.commit && wr_lvl) begin
      level_mem[idx_r] <= lvl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      sav_rd <= saved_mem[idx_r];
    end
    if (cmd.commit && wr_sav) begin
      saved_mem[idx_r] <= cur_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      sv_rd <= sv[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_id) begin
      id_row[idx_r] <= tid_r[ID_W-1:0];
    end
  end

  always_comb begin
    ok          = 1'b0;
    lvl_new     = cur_rd;
    sv_new      = sv_rd;
    wr_lvl      = 1'b0;
    wr_sav      = 1'b0;
    wr_id       = 1'b0;
    set_used    = 1'b0;
    clr_used    = 1'b0;
    res_found   = 1'b0;
    res_changed = 1'b0;
    res_before  = '0;
    res_after   = '0;
    res_active  = 1'b0;
    unique case (cmd_r)
      CMD_ATTACH: begin
        ok = !tid_r[TID_W-1] && any_r;
        if (ok) begin
          lvl_new   = lvl_r;
          sv_new    = 1'b0;
          wr_lvl    = 1'b1;
          wr_id     = 1'b1;
          set_used  = 1'b1;
          res_found = 1'b1;
          res_after = lvl_r;
        end
      end
      CMD_FREE: begin
        ok = any_r;
        if (ok) begin
          sv_new    = 1'b0;
          clr_used  = 1'b1;
          res_found = 1'b1;
        end
      end
      CMD_SET, CMD_BOOST, CMD_RESTORE: begin
        ok = !tid_r[TID_W-1] && any_r;
        if (ok) begin
          if (cmd_r == CMD_SET) begin
            lvl_new = lvl_r;
          end else if (cmd_r == CMD_BOOST) begin
            if (lvl_r < cur_rd) begin
              // keep the original level only on the first donation
              wr_sav  = !sv_rd;
              sv_new  = 1'b1;
              lvl_new = lvl_r;
            end
          end else if (sv_rd) begin
            lvl_new = sav_rd;
            sv_new  = 1'b0;
          end
          wr_lvl      = 1'b1;
          res_found   = 1'b1;
          res_before  = cur_rd;
          res_after   = lvl_new;
          res_changed = (lvl_new != cur_rd);
          res_active  = sv_new;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      sv   <= '0;
    end else if (cmd.commit && ok) begin
      if (set_used) used[idx_r] <= 1'b1;
      if (clr_used) used[idx_r] <= 1'b0;
      sv[idx_r] <= sv_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found   <= res_found;
      out_changed <= res_changed;
      out_before  <= res_before;
      out_after   <= res_after;
      out_active  <= res_active;
    end
  end

  assign stat.out_busy       = out_valid && !rsp.ready;
  assign rsp.valid           = out_valid;
  assign rsp.found           = out_found;
  assign rsp.changed         = out_changed;
  assign rsp.level_before    = out_before;
  assign rsp.level_after     = out_after;
  assign rsp.donation_active = out_active;

endmodule

`default_nettype wire

/* hw/rtl/priority_donation_table_core.sv */
// top level of the priority donation table
// a result is registered at write-back, after the compare, pick and read states that follow its request
// a new request is taken only after the previous command has passed the compare, pick,
//   memory read and write-back steps, and is held off while the response is stalled
// reset: synchronous; clears the used and saved-valid flags,
//   ids and levels are written by attach before they are read
`default_nettype none

module priority_donation_table_core
  import pdt_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  pdt_req_if.sink   req,
  pdt_rsp_if.source rsp
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdt_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while a command is in flight");

  // write-back never overwrites a pending response
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp.valid && !rsp.ready))
    else $error("commit while response is stalled");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("committed result not presented");

  // a command reaches write-back after the compare, pick and read states that follow acceptance
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> ##4 (cmd.commit || stat.out_busy))
    else $error("command did not reach write-back in time");

endmodule

`default_nettype wire
